// ----- hdl/bgm_pkg.sv -----
`timescale 1ns / 1ps

package bgm_pkg;

    typedef struct packed {
        logic accept;
        logic scale;
        logic segment;
        logic finish;
    } bgm_cmd_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THR   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REARM_THR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIM_EN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIM_MV    = 3'd3;

    localparam logic [6:0]  LOW_THR_RESET   = 7'd10;
    localparam logic [6:0]  REARM_THR_RESET = 7'd12;

    localparam logic [1:0] SYS_SLEEP   = 2'd1;
    localparam logic [1:0] SYS_STANDBY = 2'd2;

    localparam logic [1:0] SLEEP_NONE  = 2'd0;
    localparam logic [1:0] SLEEP_LIGHT = 2'd1;
    localparam logic [1:0] SLEEP_DEEP  = 2'd2;

    // battery mv = floor(pin * 6000 / 1989), via rounded-up reciprocal
    localparam int unsigned MV_SHIFT  = 23;
    localparam int unsigned MV_MULT_W = 25;
    localparam longint unsigned MV_MULT_L =
        ((64'd1 << MV_SHIFT) * 64'd6000 + 64'd1988) / 64'd1989;
    localparam logic [MV_MULT_W-1:0] MV_MULT = MV_MULT_L[MV_MULT_W-1:0];
    localparam int unsigned MV_PROD_W = 12 + MV_MULT_W;

    // interpolation quotient by rounded-up reciprocal of twice the segment width
    localparam int unsigned DIV_SHIFT = 22;
    localparam int unsigned RECIP_W   = 15;
    localparam int unsigned RECIP_600_I = ((32'd1 << DIV_SHIFT) + 32'd599) / 32'd600;
    localparam int unsigned RECIP_300_I = ((32'd1 << DIV_SHIFT) + 32'd299) / 32'd300;
    localparam int unsigned RECIP_200_I = ((32'd1 << DIV_SHIFT) + 32'd199) / 32'd200;
    localparam logic [RECIP_W-1:0] RECIP_600 = RECIP_600_I[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP_300 = RECIP_300_I[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP_200 = RECIP_200_I[RECIP_W-1:0];

    localparam logic [13:0] BP_MV [8] = '{
        14'd3200, 14'd3500, 14'd3650, 14'd3750,
        14'd3850, 14'd3950, 14'd4050, 14'd4200
    };
    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [6:0] PCT_EMPTY = 7'd0;

    typedef struct packed {
        logic [13:0]        v0;
        logic [6:0]         p0;
        logic [4:0]         dp;
        logic [8:0]         dv;
        logic [RECIP_W-1:0] recip;
    } bgm_seg_t;

    function automatic bgm_seg_t seg_lookup(input logic [2:0] idx);
        bgm_seg_t s;
        case (idx)
            3'd0: s = '{v0: 14'd3200, p0: 7'd0,  dp: 5'd5,  dv: 9'd300, recip: RECIP_600};
            3'd1: s = '{v0: 14'd3500, p0: 7'd5,  dp: 5'd5,  dv: 9'd150, recip: RECIP_300};
            3'd2: s = '{v0: 14'd3650, p0: 7'd10, dp: 5'd15, dv: 9'd100, recip: RECIP_200};
            3'd3: s = '{v0: 14'd3750, p0: 7'd25, dp: 5'd25, dv: 9'd100, recip: RECIP_200};
            3'd4: s = '{v0: 14'd3850, p0: 7'd50, dp: 5'd20, dv: 9'd100, recip: RECIP_200};
            3'd5: s = '{v0: 14'd3950, p0: 7'd70, dp: 5'd15, dv: 9'd100, recip: RECIP_200};
            3'd6: s = '{v0: 14'd4050, p0: 7'd85, dp: 5'd15, dv: 9'd150, recip: RECIP_300};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/bgm_ctrl.sv -----
`timescale 1ns / 1ps

module bgm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bgm_pkg::bgm_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SEGMENT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.accept  = (state_reg == ST_IDLE) && s_valid;
        cmd.scale   = (state_reg == ST_SCALE);
        cmd.segment = (state_reg == ST_SEGMENT);
        cmd.finish  = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    state_reg <= ST_SEGMENT;
                end
                ST_SEGMENT: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/bgm_datapath.sv -----
`timescale 1ns / 1ps

module bgm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bgm_pkg::bgm_cmd_t                  cmd,
    input  logic                               cfg_write,
    input  logic [bgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bgm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [11:0]                        pin_mv,
    input  logic                               charging,
    input  logic [1:0]                         system_state,
    input  logic                               sleep_ok,
    output logic [13:0]                        battery_mv,
    output logic [6:0]                         percent,
    output logic                               charge_start,
    output logic                               charge_done,
    output logic                               low_battery,
    output logic [1:0]                         sleep_action
);

    // configuration
    logic [6:0]  low_thr_reg;
    logic [6:0]  rearm_thr_reg;
    logic        sim_en_reg;
    logic [13:0] sim_mv_reg;

    // item state
    logic                          last_charging_reg;
    logic                          low_reported_reg;

    // working registers
    logic [bgm_pkg::MV_PROD_W-1:0] prod_reg;
    logic                          charging_reg;
    logic [1:0]                    sys_reg;
    logic                          allow_reg;
    logic [13:0]                   mv_reg;
    logic [12:0]                   n_reg;
    logic [bgm_pkg::RECIP_W-1:0]   recip_reg;
    logic [6:0]                    p0_reg;

    // output registers
    logic [13:0] out_mv_reg;
    logic [6:0]  out_pct_reg;
    logic        out_start_reg;
    logic        out_done_reg;
    logic        out_low_reg;
    logic [1:0]  out_sleep_reg;

    // segment stage
    logic              clamp_lo;
    logic              clamp_hi;
    logic [2:0]        seg_idx;
    bgm_pkg::bgm_seg_t seg;
    logic [8:0]        diff;
    logic [13:0]       scaled;
    logic [14:0]       n_full;

    // finishing stage
    logic [bgm_pkg::DIV_SHIFT+5:0] q_prod;
    logic [6:0]                    pct;
    logic                          ev_start;
    logic                          ev_done;
    logic                          ev_low;
    logic                          low_reported_next;
    logic [1:0]                    sleep_next;

    always_comb begin
        clamp_lo = (mv_reg <= bgm_pkg::BP_MV[0]);
        clamp_hi = (mv_reg > bgm_pkg::BP_MV[7]);
        seg_idx  = 3'd6;
        for (int i = 6; i >= 0; i--) begin
            if (mv_reg <= bgm_pkg::BP_MV[i+1]) begin
                seg_idx = 3'(i);
            end
        end
        seg    = bgm_pkg::seg_lookup(seg_idx);
        diff   = 9'(mv_reg - seg.v0);
        scaled = 14'(diff * seg.dp);
        n_full = {scaled, 1'b0} + {6'd0, seg.dv};
    end

    always_comb begin
        q_prod   = n_reg * recip_reg;
        pct      = p0_reg + {1'b0, q_prod[bgm_pkg::DIV_SHIFT+5:bgm_pkg::DIV_SHIFT]};
        ev_start = charging_reg && (!last_charging_reg || sys_reg == bgm_pkg::SYS_SLEEP);
        ev_done  = !charging_reg && last_charging_reg;
        ev_low   = (pct < low_thr_reg) && !charging_reg && !low_reported_reg;
        if (ev_low) begin
            low_reported_next = 1'b1;
        end else if ((pct >= rearm_thr_reg) || charging_reg) begin
            low_reported_next = 1'b0;
        end else begin
            low_reported_next = low_reported_reg;
        end
        sleep_next = bgm_pkg::SLEEP_NONE;
        if (allow_reg) begin
            if (sys_reg == bgm_pkg::SYS_SLEEP) begin
                sleep_next = bgm_pkg::SLEEP_DEEP;
            end else if (sys_reg == bgm_pkg::SYS_STANDBY) begin
                sleep_next = bgm_pkg::SLEEP_LIGHT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg       <= bgm_pkg::LOW_THR_RESET;
            rearm_thr_reg     <= bgm_pkg::REARM_THR_RESET;
            sim_en_reg        <= 1'b0;
            sim_mv_reg        <= '0;
            last_charging_reg <= 1'b0;
            low_reported_reg  <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    bgm_pkg::REG_LOW_THR:   low_thr_reg   <= cfg_data[6:0];
                    bgm_pkg::REG_REARM_THR: rearm_thr_reg <= cfg_data[6:0];
                    bgm_pkg::REG_SIM_EN:    sim_en_reg    <= cfg_data[0];
                    bgm_pkg::REG_SIM_MV:    sim_mv_reg    <= cfg_data[13:0];
                    default: ;
                endcase
            end
            if (cmd.finish) begin
                last_charging_reg <= charging_reg;
                low_reported_reg  <= low_reported_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            prod_reg     <= {{bgm_pkg::MV_MULT_W{1'b0}}, pin_mv} *
                            {12'd0, bgm_pkg::MV_MULT};
            charging_reg <= charging;
            sys_reg      <= system_state;
            allow_reg    <= sleep_ok;
        end
        if (cmd.scale) begin
            mv_reg <= sim_en_reg ? sim_mv_reg
                                 : prod_reg[bgm_pkg::MV_SHIFT+13:bgm_pkg::MV_SHIFT];
        end
        if (cmd.segment) begin
            n_reg     <= (clamp_lo || clamp_hi) ? 13'd0 : n_full[12:0];
            recip_reg <= seg.recip;
            if (clamp_lo) begin
                p0_reg <= bgm_pkg::PCT_EMPTY;
            end else if (clamp_hi) begin
                p0_reg <= bgm_pkg::PCT_FULL;
            end else begin
                p0_reg <= seg.p0;
            end
        end
        if (cmd.finish) begin
            out_mv_reg    <= mv_reg;
            out_pct_reg   <= pct;
            out_start_reg <= ev_start;
            out_done_reg  <= ev_done;
            out_low_reg   <= ev_low;
            out_sleep_reg <= sleep_next;
        end
    end

    assign battery_mv   = out_mv_reg;
    assign percent      = out_pct_reg;
    assign charge_start = out_start_reg;
    assign charge_done  = out_done_reg;
    assign low_battery  = out_low_reg;
    assign sleep_action = out_sleep_reg;

endmodule

// ----- hdl/battery_gauge_monitor.sv -----
`timescale 1ns / 1ps

// battery check monitor: each accepted check scales the divider pin voltage to battery
// millivolts (or takes the simulated value), interpolates percent over fixed breakpoints
// and raises charger, low battery and sleep events. the scaling multiply runs at the input
// transfer, then the controller steps through voltage select, segment lookup and reciprocal
// multiply, and the result is registered at the end of that last step; a new check is
// taken only once the previous one has left its last step, and a result left waiting holds
// the next check in its last step. configuration is always ready and must only be written
// while no check is in flight.
module battery_gauge_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [11:0]                     s_pin_mv,
    input  logic                            s_charging,
    input  logic [1:0]                      s_system_state,
    input  logic                            s_sleep_ok,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [13:0]                     m_battery_mv,
    output logic [6:0]                      m_percent,
    output logic                            m_charge_start,
    output logic                            m_charge_done,
    output logic                            m_low_battery,
    output logic [1:0]                      m_sleep_action
);

    bgm_pkg::bgm_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bgm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bgm_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pin_mv       (s_pin_mv),
        .charging     (s_charging),
        .system_state (s_system_state),
        .sleep_ok     (s_sleep_ok),
        .battery_mv   (m_battery_mv),
        .percent      (m_percent),
        .charge_start (m_charge_start),
        .charge_done  (m_charge_done),
        .low_battery  (m_low_battery),
        .sleep_action (m_sleep_action)
    );

endmodule

// ----- test/battery_gauge_monitor_tb.sv -----
`timescale 1ns / 1ps

module battery_gauge_monitor_tb;

    localparam logic [1:0] SYS_OTHER    = 2'd0;
    localparam logic [1:0] SYS_RESERVED = 2'd3;

    localparam logic [bgm_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [bgm_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam int unsigned DIVIDER_NUM = 30000;
    localparam int unsigned DIVIDER_DEN = 9945;
    localparam int unsigned KNEE_MV  [8] = '{3200, 3500, 3650, 3750, 3850, 3950, 4050, 4200};
    localparam int unsigned KNEE_PCT [8] = '{0, 5, 10, 25, 50, 70, 85, 100};
    localparam logic [13:0] SIM_POINTS [5] = '{14'd3200, 14'd4200, 14'd4201, 14'h3FFF, 14'd10000};

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 10;
    localparam int PHASE_CHECKS   = 60;

    typedef struct packed {
        logic [11:0] pin_mv;
        logic        charging;
        logic [1:0]  system_state;
        logic        sleep_ok;
    } check_t;

    typedef struct packed {
        logic [13:0] battery_mv;
        logic [6:0]  percent;
        logic        charge_start;
        logic        charge_done;
        logic        low_battery;
        logic [1:0]  sleep_action;
    } gauge_t;

    typedef enum logic [1:0] {
        STEP_CHECK,
        STEP_WRITE,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t                      kind;
        check_t                          chk;
        logic [bgm_pkg::CFG_INDEX_W-1:0] idx;
        logic [bgm_pkg::CFG_DATA_W-1:0]  data;
        logic                            quiet;
    } step_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bgm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bgm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [11:0]                     s_pin_mv = '0;
    logic                            s_charging = 1'b0;
    logic [1:0]                      s_system_state = '0;
    logic                            s_sleep_ok = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [13:0]                     m_battery_mv;
    logic [6:0]                      m_percent;
    logic                            m_charge_start;
    logic                            m_charge_done;
    logic                            m_low_battery;
    logic [1:0]                      m_sleep_action;

    battery_gauge_monitor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pin_mv       (s_pin_mv),
        .s_charging     (s_charging),
        .s_system_state (s_system_state),
        .s_sleep_ok     (s_sleep_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_battery_mv   (m_battery_mv),
        .m_percent      (m_percent),
        .m_charge_start (m_charge_start),
        .m_charge_done  (m_charge_done),
        .m_low_battery  (m_low_battery),
        .m_sleep_action (m_sleep_action)
    );

    step_t  plan_q [$];
    gauge_t gauge_q [$];
    int     n_planned = 0;

    // driver side
    int   send_gap = 0;
    int   settle_cnt = 0;
    int   n_sent = 0;
    logic quiet_now = 1'b0;

    // monitor side and gauge state
    int          n_checked = 0;
    int          n_fail = 0;
    int          n_writes = 0;
    int          n_low_events = 0;
    int          n_charger_events = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    logic [6:0]  gauge_low_thr = bgm_pkg::LOW_THR_RESET;
    logic [6:0]  gauge_rearm_thr = bgm_pkg::REARM_THR_RESET;
    logic        gauge_sim_en = 1'b0;
    logic [13:0] gauge_sim_mv = '0;
    logic        was_charging = 1'b0;
    logic        low_latched = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic check_t check_of(input logic [11:0] pin, input logic chg,
                                        input logic [1:0] sys, input logic permit);
        check_t c;
        c.pin_mv       = pin;
        c.charging     = chg;
        c.system_state = sys;
        c.sleep_ok     = permit;
        return c;
    endfunction

    task automatic plan_check(input check_t c, input logic quiet);
        step_t s;
        s = '0;
        s.kind  = STEP_CHECK;
        s.chk   = c;
        s.quiet = quiet;
        plan_q.push_back(s);
        n_planned++;
    endtask

    task automatic plan_write(input logic [bgm_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [bgm_pkg::CFG_DATA_W-1:0] data);
        step_t s;
        s = '0;
        s.kind = STEP_WRITE;
        s.idx  = idx;
        s.data = data;
        plan_q.push_back(s);
    endtask

    task automatic plan_drain();
        step_t s;
        s = '0;
        s.kind = STEP_DRAIN;
        plan_q.push_back(s);
    endtask

    function automatic logic [6:0] soc_from_mv(input logic [13:0] mv);
        int unsigned v, span, rise, pct;
        v   = mv;
        pct = 100;
        if (v <= KNEE_MV[0]) begin
            pct = 0;
        end else begin
            for (int k = 7; k >= 1; k--) begin
                if (v <= KNEE_MV[k]) begin
                    span = KNEE_MV[k] - KNEE_MV[k-1];
                    rise = KNEE_PCT[k] - KNEE_PCT[k-1];
                    pct  = KNEE_PCT[k-1] + (2 * (v - KNEE_MV[k-1]) * rise + span) / (2 * span);
                end
            end
        end
        return 7'(pct);
    endfunction

    function automatic void apply_write(input logic [bgm_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [bgm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bgm_pkg::REG_LOW_THR:   gauge_low_thr = data[6:0];
            bgm_pkg::REG_REARM_THR: gauge_rearm_thr = data[6:0];
            bgm_pkg::REG_SIM_EN:    gauge_sim_en = data[0];
            bgm_pkg::REG_SIM_MV:    gauge_sim_mv = data;
            default: ;
        endcase
    endfunction

    function automatic gauge_t predict_check(input check_t c);
        gauge_t      r;
        int unsigned mv;
        if (gauge_sim_en) begin
            mv = gauge_sim_mv;
        end else begin
            mv = int'(c.pin_mv) * DIVIDER_NUM / DIVIDER_DEN;
        end
        r.battery_mv   = 14'(mv);
        r.percent      = soc_from_mv(14'(mv));
        r.charge_start = c.charging &&
                         (!was_charging || c.system_state == bgm_pkg::SYS_SLEEP);
        r.charge_done  = !c.charging && was_charging;
        was_charging   = c.charging;
        r.low_battery  = 1'b0;
        if (r.percent < gauge_low_thr && !c.charging && !low_latched) begin
            r.low_battery = 1'b1;
            low_latched   = 1'b1;
        end else if (r.percent >= gauge_rearm_thr || c.charging) begin
            low_latched = 1'b0;
        end
        r.sleep_action = bgm_pkg::SLEEP_NONE;
        if (c.sleep_ok) begin
            if (c.system_state == bgm_pkg::SYS_SLEEP) begin
                r.sleep_action = bgm_pkg::SLEEP_DEEP;
            end else if (c.system_state == bgm_pkg::SYS_STANDBY) begin
                r.sleep_action = bgm_pkg::SLEEP_LIGHT;
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        logic s_valid_n, cfg_valid_n;
        int   gap_n, settle_n, sent_n;
        step_t head;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            s_valid_n   = s_valid;
            cfg_valid_n = cfg_valid;
            gap_n       = send_gap;
            settle_n    = settle_cnt;
            sent_n      = n_sent;
            if (s_valid && s_ready) begin
                s_valid_n = 1'b0;
                sent_n    = sent_n + 1;
                if (!quiet_now && $urandom_range(99, 0) < 30) begin
                    gap_n = $urandom_range(8, 1);
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_valid_n = 1'b0;
            end
            if (!s_valid_n && !cfg_valid_n && plan_q.size() != 0) begin
                if (gap_n != 0) begin
                    gap_n = gap_n - 1;
                end else begin
                    head = plan_q[0];
                    case (head.kind)
                        STEP_CHECK: begin
                            s_valid_n      = 1'b1;
                            s_pin_mv       <= head.chk.pin_mv;
                            s_charging     <= head.chk.charging;
                            s_system_state <= head.chk.system_state;
                            s_sleep_ok     <= head.chk.sleep_ok;
                            quiet_now      <= head.quiet;
                            void'(plan_q.pop_front());
                        end
                        STEP_WRITE: begin
                            cfg_valid_n = 1'b1;
                            cfg_index   <= head.idx;
                            cfg_data    <= head.data;
                            void'(plan_q.pop_front());
                        end
                        default: begin
                            if (sent_n == n_checked) begin
                                if (settle_n >= SETTLE_CYCLES) begin
                                    settle_n = 0;
                                    void'(plan_q.pop_front());
                                end else begin
                                    settle_n = settle_n + 1;
                                end
                            end
                        end
                    endcase
                end
            end
            s_valid    <= s_valid_n;
            cfg_valid  <= cfg_valid_n;
            send_gap   <= gap_n;
            settle_cnt <= settle_n;
            n_sent     <= sent_n;
        end
    end

    // monitor
    always @(posedge aclk) begin
        gauge_t seen, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
                n_writes++;
            end
            if (s_valid && s_ready) begin
                gauge_q.push_back(predict_check(check_of(s_pin_mv, s_charging,
                                                         s_system_state, s_sleep_ok)));
            end
            if (m_valid && m_ready) begin
                seen = {m_battery_mv, m_percent, m_charge_start, m_charge_done,
                        m_low_battery, m_sleep_action};
                if (gauge_q.size() == 0) begin
                    if (n_fail < 10) begin
                        $display("unexpected result: mv %0d pct %0d", m_battery_mv, m_percent);
                    end
                    n_fail++;
                end else begin
                    want = gauge_q.pop_front();
                    if (seen !== want) begin
                        if (n_fail < 10) begin
                            $display("mismatch on check %0d: expected mv %0d pct %0d start %b %s",
                                     n_checked, want.battery_mv, want.percent,
                                     want.charge_start,
                                     $sformatf("done %b low %b sleep %0d", want.charge_done,
                                               want.low_battery, want.sleep_action));
                            $display("    got mv %0d pct %0d start %b done %b low %b sleep %0d",
                                     seen.battery_mv, seen.percent, seen.charge_start,
                                     seen.charge_done, seen.low_battery, seen.sleep_action);
                        end
                        n_fail++;
                    end
                    if (want.low_battery) n_low_events++;
                    if (want.charge_start || want.charge_done) n_charger_events++;
                    n_checked <= n_checked + 1;
                end
            end
            if (stall_left != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet_now && $urandom_range(99, 0) < 12) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(7, 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          walk, pin, pick;
        logic        chg, quiet, sim_on;
        logic [6:0]  lo, re;
        logic [13:0] sim_val;

        // divider scaling, charger edges, sleep requests and low battery latch
        plan_check(check_of(12'd0, 1'b0, SYS_OTHER, 1'b0), 1'b0);
        plan_check(check_of(12'hFFF, 1'b1, bgm_pkg::SYS_SLEEP, 1'b1), 1'b0);
        plan_check(check_of(12'hFFF, 1'b1, bgm_pkg::SYS_SLEEP, 1'b0), 1'b0);
        plan_check(check_of(12'hFFF, 1'b1, bgm_pkg::SYS_STANDBY, 1'b1), 1'b0);
        plan_check(check_of(12'd1061, 1'b0, SYS_RESERVED, 1'b1), 1'b0);
        plan_check(check_of(12'd1061, 1'b0, SYS_OTHER, 1'b1), 1'b0);
        plan_check(check_of(12'd1160, 1'b0, bgm_pkg::SYS_STANDBY, 1'b0), 1'b0);
        plan_check(check_of(12'd1210, 1'b0, bgm_pkg::SYS_SLEEP, 1'b1), 1'b0);
        plan_check(check_of(12'd1243, 1'b0, SYS_OTHER, 1'b0), 1'b0);
        plan_check(check_of(12'd1276, 1'b1, SYS_OTHER, 1'b0), 1'b0);
        plan_check(check_of(12'd1310, 1'b1, bgm_pkg::SYS_STANDBY, 1'b1), 1'b0);
        plan_check(check_of(12'd1343, 1'b0, SYS_OTHER, 1'b0), 1'b0);
        plan_check(check_of(12'd1400, 1'b0, SYS_RESERVED, 1'b0), 1'b0);
        plan_check(check_of(12'd3300, 1'b0, SYS_OTHER, 1'b1), 1'b0);
        plan_check(check_of(12'd1061, 1'b0, SYS_OTHER, 1'b0), 1'b0);

        // simulated voltage at the table ends and beyond
        plan_drain();
        plan_write(bgm_pkg::REG_SIM_EN, 14'd1);
        for (int i = 0; i < 5; i++) begin
            plan_drain();
            plan_write(bgm_pkg::REG_SIM_MV, SIM_POINTS[i]);
            plan_check(check_of(12'd0, 1'b0, SYS_OTHER, 1'b0), 1'b0);
        end

        // thresholds above full scale
        plan_drain();
        plan_write(bgm_pkg::REG_LOW_THR, 14'h3FFF);
        plan_write(bgm_pkg::REG_REARM_THR, 14'h3FFF);
        plan_write(REG_SPARE_LAST, 14'h3FFF);
        plan_check(check_of(12'd0, 1'b0, SYS_OTHER, 1'b0), 1'b0);
        plan_check(check_of(12'd0, 1'b0, SYS_OTHER, 1'b0), 1'b0);
        plan_check(check_of(12'd0, 1'b1, SYS_OTHER, 1'b0), 1'b0);

        walk = 1200;
        chg  = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet = (ph == 3) || (ph == PHASES - 1);
            case ($urandom_range(9, 0))
                0:       lo = 7'd0;
                1:       lo = 7'd100;
                2:       lo = 7'd127;
                default: lo = 7'($urandom_range(30, 3));
            endcase
            case ($urandom_range(9, 0))
                0:       re = 7'd0;
                1:       re = 7'd100;
                2:       re = 7'd127;
                3:       re = 7'($urandom_range(127, 0));
                default: re = (lo > 7'd122) ? 7'd127 : lo + 7'($urandom_range(5, 0));
            endcase
            sim_on = (ph == 4) || ($urandom_range(4, 0) == 0);
            case ($urandom_range(7, 0))
                0:       sim_val = 14'd0;
                1:       sim_val = 14'd10000;
                2:       sim_val = 14'h3FFF;
                3:       sim_val = 14'($urandom);
                default: sim_val = 14'($urandom_range(4300, 3100));
            endcase
            plan_drain();
            plan_write(bgm_pkg::REG_LOW_THR, {7'($urandom), lo});
            plan_write(bgm_pkg::REG_REARM_THR, {7'($urandom), re});
            plan_write(bgm_pkg::REG_SIM_EN, {13'($urandom), sim_on});
            plan_write(bgm_pkg::REG_SIM_MV, sim_val);
            if ($urandom_range(2, 0) == 0) begin
                plan_write(3'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), 14'($urandom));
            end
            for (int i = 0; i < PHASE_CHECKS; i++) begin
                if (ph == 5 && i == PHASE_CHECKS / 2) plan_drain();
                walk = walk + $urandom_range(30, 0) - 15;
                if (walk < 1000) walk = 1000;
                if (walk > 1460) walk = 1460;
                pick = $urandom_range(99, 0);
                if (pick < 70) begin
                    pin = walk;
                end else if (pick < 85) begin
                    pin = $urandom_range(3300, 0);
                end else begin
                    pin = $urandom_range(4095, 0);
                end
                if ($urandom_range(99, 0) < 15) chg = !chg;
                plan_check(check_of(12'(pin), chg, 2'($urandom_range(3, 0)),
                                    1'($urandom_range(1, 0))), quiet);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (n_checked != n_planned);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (gauge_q.size() != 0) begin
            $display("%0d expected results never arrived", gauge_q.size());
        end
        $display("ran %0d battery checks and %0d register writes", n_checked, n_writes);
        $display("saw %0d low battery and %0d charger events, %0d failures",
                 n_low_events, n_charger_events, n_fail);
        if (n_fail == 0 && gauge_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/bgm_pkg.sv
hdl/bgm_ctrl.sv
hdl/bgm_datapath.sv
hdl/battery_gauge_monitor.sv
test/battery_gauge_monitor_tb.sv
